[sv/cde_pkg.sv]
// cde_pkg: shared widths, command and status codes, and the controller to
// datapath command and status structs for the circular deque engine.
// No dependencies.
package cde_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int CMD_W     = 3;
  localparam int ST_W      = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic push;
    logic err_full;
    logic err_empty;
    logic pop_read;
    logic pop_done;
    logic dump_read;
    logic dump_step;
  } cde_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic is_push;
    logic is_pop;
    logic is_dump;
    logic rd_last;
  } cde_stat_t;

endpackage

[sv/circular_deque_engine.sv]
// circular_deque_engine: top level of a fixed-depth double-ended queue of
// signed 32-bit values. Instantiates cde_ctrl and cde_dp; uses cde_pkg.
//
// An item (cmd_i, value_in_i) is taken at a clock edge where start_i is high
// and busy_o is low. Results come out of a register, one per cycle, each
// marked by valid_o for exactly one cycle; the receiver cannot stall them,
// and last_o marks the final result of an item. A push or any error result
// is set in S_EXEC and goes out through the result register; busy_o is
// low again while it is shown. A pop also goes through S_POP, as the slot
// memory has a registered read port; a dump stays in S_DUMP up to the last
// element, one element per cycle from that read port. Commands 5 to 7 are
// dropped without a result. No clearing pass after reset.
module circular_deque_engine import cde_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic signed [DATA_W-1:0] value_in_i,
  output logic                     valid_o,
  output logic [ST_W-1:0]          status_o,
  output logic signed [DATA_W-1:0] value_out_o,
  output logic                     last_o
);

  cde_cmd_t  cmd_ctl;
  cde_stat_t stat;

  cde_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd_ctl),
    .busy_o  (busy_o)
  );

  cde_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .value_in_i  (value_in_i),
    .cmd_ctl_i   (cmd_ctl),
    .stat_o      (stat),
    .valid_o     (valid_o),
    .status_o    (status_o),
    .value_out_o (value_out_o),
    .last_o      (last_o)
  );

endmodule

[sv/cde_ctrl.sv]
// cde_ctrl: sequencing state machine of the circular deque engine.
// Depends on cde_pkg for the command and status structs.
module cde_ctrl import cde_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  cde_stat_t stat_i,
  output cde_cmd_t  cmd_o,
  output logic      busy_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_DUMP
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        if (stat_i.is_push) begin
          if (stat_i.full) begin
            cmd_o.err_full = 1'b1;
          end else begin
            cmd_o.push = 1'b1;
          end
        end else if (stat_i.is_pop) begin
          if (stat_i.empty) begin
            cmd_o.err_empty = 1'b1;
          end else begin
            cmd_o.pop_read = 1'b1;
            state_d        = S_POP;
          end
        end else if (stat_i.is_dump) begin
          if (stat_i.empty) begin
            cmd_o.err_empty = 1'b1;
          end else begin
            cmd_o.dump_read = 1'b1;
            state_d         = S_DUMP;
          end
        end
      end
      S_POP: begin
        cmd_o.pop_done = 1'b1;
        state_d        = S_IDLE;
      end
      S_DUMP: begin
        cmd_o.dump_step = 1'b1;
        if (stat_i.rd_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
    end
  end

  assign busy_o = busy_q;

endmodule

[sv/cde_dp.sv]
// cde_dp: datapath of the circular deque engine: item register, slot
// memory, front/rear pointers, empty mark and result register.
// Depends on cde_pkg for widths, codes and the command and status structs.
module cde_dp import cde_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic signed [DATA_W-1:0] value_in_i,
  input  cde_cmd_t                 cmd_ctl_i,
  output cde_stat_t                stat_o,
  output logic                     valid_o,
  output logic [ST_W-1:0]          status_o,
  output logic signed [DATA_W-1:0] value_out_o,
  output logic                     last_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PW-1:0] PMAX = PW'(DEPTH - 1);

  function automatic logic [PW-1:0] fwd(input logic [PW-1:0] p);
    fwd = (p == PMAX) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] back(input logic [PW-1:0] p);
    back = (p == '0) ? PMAX : p - PW'(1);
  endfunction

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  logic [CMD_W-1:0]  cmd_q;
  logic [DATA_W-1:0] val_q;

  logic [PW-1:0] head_q, head_d, tail_q, tail_d, rd_ptr_q, rd_ptr_d;
  logic          empty_q, empty_d;

  logic              valid_q, valid_d;
  logic [ST_W-1:0]   status_q, status_d;
  logic [DATA_W-1:0] value_q, value_d;
  logic              last_q, last_d;

  logic          we, re;
  logic [PW-1:0] waddr, raddr;
  logic          front;

  assign front = (cmd_q == CMD_PUSH_FRONT) || (cmd_q == CMD_POP_FRONT);

  assign stat_o.empty   = empty_q;
  assign stat_o.full    = !empty_q && (fwd(tail_q) == head_q);
  assign stat_o.is_push = (cmd_q == CMD_PUSH_FRONT) || (cmd_q == CMD_PUSH_REAR);
  assign stat_o.is_pop  = (cmd_q == CMD_POP_FRONT) || (cmd_q == CMD_POP_REAR);
  assign stat_o.is_dump = (cmd_q == CMD_DUMP);
  assign stat_o.rd_last = (rd_ptr_q == tail_q);

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    empty_d  = empty_q;
    rd_ptr_d = rd_ptr_q;
    we       = 1'b0;
    waddr    = '0;
    re       = 1'b0;
    raddr    = head_q;
    valid_d  = 1'b0;
    status_d = status_q;
    value_d  = value_q;
    last_d   = last_q;

    if (cmd_ctl_i.push) begin
      we = 1'b1;
      if (empty_q) begin
        head_d  = '0;
        tail_d  = '0;
        empty_d = 1'b0;
        waddr   = '0;
      end else if (front) begin
        head_d = back(head_q);
        waddr  = back(head_q);
      end else begin
        tail_d = fwd(tail_q);
        waddr  = fwd(tail_q);
      end
      valid_d  = 1'b1;
      status_d = ST_OK;
      value_d  = val_q;
      last_d   = 1'b1;
    end

    if (cmd_ctl_i.err_full || cmd_ctl_i.err_empty) begin
      valid_d  = 1'b1;
      status_d = cmd_ctl_i.err_full ? ST_FULL : ST_EMPTY;
      value_d  = '0;
      last_d   = 1'b1;
    end

    if (cmd_ctl_i.pop_read) begin
      re    = 1'b1;
      raddr = front ? head_q : tail_q;
    end

    if (cmd_ctl_i.pop_done) begin
      valid_d  = 1'b1;
      status_d = ST_OK;
      value_d  = rdata_q;
      last_d   = 1'b1;
      if (head_q == tail_q) begin
        empty_d = 1'b1;
        head_d  = '0;
        tail_d  = '0;
      end else if (front) begin
        head_d = fwd(head_q);
      end else begin
        tail_d = back(tail_q);
      end
    end

    if (cmd_ctl_i.dump_read) begin
      re       = 1'b1;
      raddr    = head_q;
      rd_ptr_d = head_q;
    end

    if (cmd_ctl_i.dump_step) begin
      valid_d  = 1'b1;
      status_d = ST_OK;
      value_d  = rdata_q;
      last_d   = (rd_ptr_q == tail_q);
      re       = 1'b1;
      raddr    = fwd(rd_ptr_q);
      rd_ptr_d = fwd(rd_ptr_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= val_q;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_ctl_i.capture) begin
      cmd_q <= cmd_i;
      val_q <= value_in_i;
    end
    rd_ptr_q <= rd_ptr_d;
    status_q <= status_d;
    value_q  <= value_d;
    last_q   <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
      valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
      valid_q <= valid_d;
    end
  end

  assign valid_o     = valid_q;
  assign status_o    = status_q;
  assign value_out_o = value_q;
  assign last_o      = last_q;

endmodule

[verif/circular_deque_checker.sv]
// circular_deque_checker: watches the item and result ports of the circular
// deque engine, predicts the results of every accepted item and compares them.
// Depends on cde_pkg for widths, command and status codes.
module circular_deque_checker import cde_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     busy_i,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic signed [DATA_W-1:0] value_in_i,
  input  logic                     valid_i,
  input  logic [ST_W-1:0]          status_i,
  input  logic signed [DATA_W-1:0] value_out_i,
  input  logic                     last_i,
  output int                       pending_o,
  output int                       fail_cnt_o,
  output int                       checked_o,
  output int                       full_hits_o,
  output int                       empty_hits_o
);

  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } deque_result_t;

  deque_result_t           deque_results_q[$];
  deque_result_t           want;
  logic signed [DATA_W-1:0] slot_mem[DEPTH];
  int unsigned             front_idx = 0;
  int unsigned             rear_idx = 0;
  bit                      deque_empty = 1'b1;
  int                      fail_cnt = 0;
  int                      checked = 0;
  int                      full_hits = 0;
  int                      empty_hits = 0;

  initial pending_o = 0;
  assign fail_cnt_o   = fail_cnt;
  assign checked_o    = checked;
  assign full_hits_o  = full_hits;
  assign empty_hits_o = empty_hits;

  function automatic int unsigned next_idx(input int unsigned i);
    return (i + 1) % DEPTH;
  endfunction

  function automatic int unsigned prev_idx(input int unsigned i);
    return (i == 0) ? DEPTH - 1 : i - 1;
  endfunction

  function automatic void add_result(input logic [ST_W-1:0] st,
                                     input logic signed [DATA_W-1:0] val,
                                     input logic fin);
    deque_result_t r;
    r.status = st;
    r.value  = val;
    r.last   = fin;
    deque_results_q.push_back(r);
  endfunction

  task automatic apply_item(input logic [CMD_W-1:0] c,
                            input logic signed [DATA_W-1:0] v);
    int unsigned idx;
    logic signed [DATA_W-1:0] val;
    case (c)
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        if (!deque_empty && next_idx(rear_idx) == front_idx) begin
          add_result(ST_FULL, '0, 1'b1);
        end else begin
          if (deque_empty) begin
            front_idx = 0;
            rear_idx = 0;
            deque_empty = 1'b0;
            slot_mem[0] = v;
          end else if (c == CMD_PUSH_FRONT) begin
            front_idx = prev_idx(front_idx);
            slot_mem[front_idx] = v;
          end else begin
            rear_idx = next_idx(rear_idx);
            slot_mem[rear_idx] = v;
          end
          add_result(ST_OK, v, 1'b1);
        end
      end
      CMD_POP_FRONT, CMD_POP_REAR: begin
        if (deque_empty) begin
          add_result(ST_EMPTY, '0, 1'b1);
        end else begin
          val = slot_mem[(c == CMD_POP_FRONT) ? front_idx : rear_idx];
          if (front_idx == rear_idx) begin
            deque_empty = 1'b1;
            front_idx = 0;
            rear_idx = 0;
          end else if (c == CMD_POP_FRONT) begin
            front_idx = next_idx(front_idx);
          end else begin
            rear_idx = prev_idx(rear_idx);
          end
          add_result(ST_OK, val, 1'b1);
        end
      end
      CMD_DUMP: begin
        if (deque_empty) begin
          add_result(ST_EMPTY, '0, 1'b1);
        end else begin
          idx = front_idx;
          for (int n = 0; n < DEPTH; n++) begin
            add_result(ST_OK, slot_mem[idx], idx == rear_idx);
            if (idx == rear_idx) break;
            idx = next_idx(idx);
          end
        end
      end
      default: ;  // unused codes: dropped
    endcase
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_i) begin
        if (deque_results_q.size() == 0) begin
          $error("unexpected result: status %0d value %0d last %0d",
                 status_i, value_out_i, last_i);
          fail_cnt++;
        end else begin
          want = deque_results_q.pop_front();
          checked++;
          if (want.status == ST_FULL) full_hits++;
          if (want.status == ST_EMPTY) empty_hits++;
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            fail_cnt++;
          end
          if (value_out_i !== want.value) begin
            $error("value_out: expected %0d, got %0d", want.value, value_out_i);
            fail_cnt++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last_i);
            fail_cnt++;
          end
        end
      end
      if (start_i && !busy_i) apply_item(cmd_i, value_in_i);
    end
    pending_o <= deque_results_q.size();
  end

endmodule

[verif/circular_deque_engine_test.sv]
// circular_deque_engine_test: drives directed and random commands into the
// circular deque engine and gives the verdict from circular_deque_checker.
// Depends on cde_pkg, circular_deque_engine and circular_deque_checker.
module circular_deque_engine_test;
  import cde_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int N_RANDOM    = 405;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 6;

  localparam logic [CMD_W-1:0] CMD_UNUSED_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VAL_NEG_ONE = '1;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start_i = 1'b0;
  logic [CMD_W-1:0]         cmd_i = CMD_PUSH_FRONT;
  logic signed [DATA_W-1:0] value_in_i = '0;
  logic                     busy_o;
  logic                     valid_o;
  logic [ST_W-1:0]          status_o;
  logic signed [DATA_W-1:0] value_out_o;
  logic                     last_o;

  int pending;
  int fail_cnt;
  int checked;
  int full_hits;
  int empty_hits;

  bit          gaps_on = 1'b1;
  int          items_sent = 0;
  int unsigned cycle_cnt = 0;

  circular_deque_engine #(.DEPTH(DEPTH)) i_dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .cmd_i,
    .value_in_i,
    .valid_o,
    .status_o,
    .value_out_o,
    .last_o
  );

  circular_deque_checker #(.DEPTH(DEPTH)) i_check (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_i       (busy_o),
    .cmd_i,
    .value_in_i,
    .valid_i      (valid_o),
    .status_i     (status_o),
    .value_out_i  (value_out_o),
    .last_i       (last_o),
    .pending_o    (pending),
    .fail_cnt_o   (fail_cnt),
    .checked_o    (checked),
    .full_hits_o  (full_hits),
    .empty_hits_o (empty_hits)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic signed [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return VAL_NEG_ONE;
      default: return $urandom;
    endcase
  endfunction

  // holds start until the item is taken; leaves start high for the caller
  task automatic send_item(input logic [CMD_W-1:0] c,
                           input logic signed [DATA_W-1:0] v);
    while (gaps_on && $urandom_range(0, 99) < 33) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i    <= 1'b1;
    cmd_i      <= c;
    value_in_i <= v;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [CMD_W-1:0]         c;
    logic signed [DATA_W-1:0] v;
    int                       mode;
    int                       roll;
    int                       n;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // errors on an empty deque, then the unused codes
    send_item(CMD_POP_FRONT, rand_value());
    send_item(CMD_POP_REAR, rand_value());
    send_item(CMD_DUMP, rand_value());
    send_item(CMD_UNUSED_5, rand_value());
    send_item(CMD_UNUSED_6, rand_value());
    send_item(CMD_UNUSED_7, rand_value());
    // single element in and out
    send_item(CMD_PUSH_FRONT, VAL_MIN);
    send_item(CMD_POP_REAR, '0);
    // fill to capacity from both ends, wrapping the front pointer
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0: v = VAL_MAX;
        1: v = '0;
        2: v = VAL_NEG_ONE;
        3: v = VAL_MIN;
        default: v = $urandom;
      endcase
      send_item((i % 2 == 0) ? CMD_PUSH_FRONT : CMD_PUSH_REAR, v);
    end
    send_item(CMD_PUSH_FRONT, rand_value());
    send_item(CMD_PUSH_REAR, rand_value());
    send_item(CMD_DUMP, '0);
    send_item(CMD_POP_FRONT, '0);
    send_item(CMD_POP_REAR, '0);
    wait_drained();

    // random phases: fill-biased, drain-biased, balanced
    n = 0;
    mode = 0;
    while (n < N_RANDOM) begin
      if (n % 30 == 0) mode = $urandom_range(0, 2);
      gaps_on = !(n >= 150 && n < 250);
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        case ($urandom_range(0, 2))
          0: c = CMD_UNUSED_5;
          1: c = CMD_UNUSED_6;
          default: c = CMD_UNUSED_7;
        endcase
        send_item(c, rand_value());
      end else begin
        if (roll < 10) begin
          c = CMD_DUMP;
        end else if ($urandom_range(0, 99) < ((mode == 0) ? 80 : (mode == 1) ? 20 : 50)) begin
          c = $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
        end else begin
          c = $urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT;
        end
        send_item(c, rand_value());
        n++;
        if (n == 200) wait_drained();
      end
    end

    wait_drained();
    $display("%0d items sent, %0d results checked", items_sent, checked);
    $display("errors seen: %0d on a full deque, %0d on an empty one",
             full_hits, empty_hits);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
